[design/sts_pkg.sv]
package sts_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int POS_W       = 7;

  // Port requests from the sequencer to the key table.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             inserted;
    logic             table_full;
  } result_t;

endpackage

[design/sorted_table_search_insert.sv]
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_stall | search_key (32, signed)
// output   | out_valid/out_stall | found, position (7), inserted, table_full
//
// An item's time grows with the binary search over n, the fill count, and for
// an insert with s, the larger entries moved; one probe or one move per cycle
// through the key table's separate read and write ports sets this.
// Reset clears the fill count, so the table starts empty; contents need none.
// in_stall is high from acceptance until the result enters the output
// register; a stalled result holds there while the next item is searched.
module sorted_table_search_insert (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sts_pkg::KEY_W-1:0]   search_key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [sts_pkg::POS_W-1:0]   position,
  output logic                        inserted,
  output logic                        table_full
);

  sts_pkg::ram_req_t          ram_req;
  logic [sts_pkg::KEY_W-1:0]  ram_rdata;
  logic                       res_valid;
  logic                       res_take;
  sts_pkg::result_t           res;
  sts_pkg::result_t           out_q;

  // Key table: sorted ascending over the filled part.
  sts_ram #(
    .WIDTH (sts_pkg::KEY_W),
    .DEPTH (sts_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rdata)
  );

  // Sequencer: binary search, match test, entry shift and insert.
  sts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .search_key (search_key),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // Load the output register when it is empty or being drained.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; advance only on a fresh result.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign found      = out_q.found;
  assign position   = out_q.position;
  assign inserted   = out_q.inserted;
  assign table_full = out_q.table_full;

endmodule

[design/sts_ram.sv]
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/sts_ctrl.sv]
module sts_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [sts_pkg::KEY_W-1:0] search_key,
  output sts_pkg::ram_req_t         ram_req,
  input  logic [sts_pkg::KEY_W-1:0] ram_rdata,
  output logic                      res_valid,
  input  logic                      res_take,
  output sts_pkg::result_t          res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_CHK   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_INS   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                      state, state_next;
  logic [sts_pkg::CNT_W-1:0]   count;
  logic [sts_pkg::CNT_W-1:0]   lo, lo_next;
  logic [sts_pkg::CNT_W-1:0]   hi, hi_next;
  logic [sts_pkg::CNT_W-1:0]   mid_w;
  logic [sts_pkg::IDX_W-1:0]   mid;
  logic                        pend;
  logic [sts_pkg::IDX_W-1:0]   widx;
  logic [sts_pkg::KEY_W-1:0]   key;
  sts_pkg::result_t            res_q;
  logic                        key_lt;
  logic                        hit;
  logic                        is_full;

  // Shared compare unit: one table entry against the held key.
  assign key_lt  = $signed(ram_rdata) < $signed(key);
  assign hit     = (lo < count) && (ram_rdata == key);
  assign is_full = count == sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH);

  // Narrow the search window with the entry read last cycle.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (pend) begin
      if (key_lt) begin
        lo_next = sts_pkg::CNT_W'(mid) + sts_pkg::CNT_W'(1);
      end else begin
        hi_next = sts_pkg::CNT_W'(mid);
      end
    end
    mid_w = lo_next + ((hi_next - lo_next) >> 1);
  end

  always_comb begin
    state_next      = state;
    ram_req         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        ram_req.rd_en = 1'b1;
        if (lo_next < hi_next) begin
          ram_req.rd_addr = mid_w[sts_pkg::IDX_W-1:0];
        end else begin
          // Fetch the entry at the lower bound for the match test.
          ram_req.rd_addr = lo_next[sts_pkg::IDX_W-1:0];
          state_next      = S_CHK;
        end
      end
      S_CHK: begin
        if (hit || is_full) begin
          state_next = S_DONE;
        end else if (count > lo) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = sts_pkg::IDX_W'(count - sts_pkg::CNT_W'(1));
          state_next      = S_SHIFT;
        end else begin
          state_next = S_INS;
        end
      end
      S_SHIFT: begin
        // Move one entry up while fetching the one below it.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = widx;
        ram_req.wr_data = ram_rdata;
        if (sts_pkg::CNT_W'(widx) > lo + sts_pkg::CNT_W'(1)) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = widx - sts_pkg::IDX_W'(2);
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = lo[sts_pkg::IDX_W-1:0];
        ram_req.wr_data = key;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key  <= search_key;
            lo   <= '0;
            hi   <= count;
            pend <= 1'b0;
          end
        end
        S_SRCH: begin
          lo   <= lo_next;
          hi   <= hi_next;
          mid  <= mid_w[sts_pkg::IDX_W-1:0];
          pend <= lo_next < hi_next;
        end
        S_CHK: begin
          pend                 <= 1'b0;
          widx                 <= count[sts_pkg::IDX_W-1:0];
          res_q.found          <= hit;
          res_q.position       <= sts_pkg::POS_W'(lo);
          res_q.inserted       <= !hit && !is_full;
          res_q.table_full     <= !hit && is_full;
        end
        S_SHIFT: begin
          widx <= widx - sts_pkg::IDX_W'(1);
        end
        S_INS: begin
          count <= count + sts_pkg::CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = state != S_IDLE;
  assign res_valid = state == S_DONE;
  assign res       = res_q;

endmodule

[dv/table_result_checker.sv]
module table_result_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [sts_pkg::KEY_W-1:0] search_key,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      found,
  input  logic [sts_pkg::POS_W-1:0] position,
  input  logic                      inserted,
  input  logic                      table_full,
  output int                        fail_count,
  output int                        results_pending
);
  import sts_pkg::*;

  logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int                      shadow_fill;
  result_t                 pending_outcomes [$];
  int                      mismatches;

  // Search the filled part for the first entry not below the key, then
  // record a match, a refusal on a full table, or an ordered insert.
  function automatic result_t lookup_and_insert(input logic signed [KEY_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    int      n;
    int      i;
    result_t outcome;
    n  = (shadow_fill > TABLE_DEPTH) ? TABLE_DEPTH : shadow_fill;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    outcome          = '0;
    outcome.position = lo[POS_W-1:0];
    if (lo < n && shadow_keys[lo] == key) begin
      outcome.found = 1'b1;
    end else if (n >= TABLE_DEPTH) begin
      outcome.table_full = 1'b1;
    end else begin
      for (i = n; i > lo; i--) shadow_keys[i] = shadow_keys[i-1];
      shadow_keys[lo]  = key;
      shadow_fill      = n + 1;
      outcome.inserted = 1'b1;
    end
    return outcome;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      shadow_fill = 0;
      pending_outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          if (found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", found, want.found));
          if (position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
          if (inserted !== want.inserted)
            report_mismatch($sformatf("inserted %b, expected %b", inserted, want.inserted));
          if (table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, expected %b", table_full,
                                      want.table_full));
        end
      end
      if (in_valid && !in_stall)
        pending_outcomes.push_back(lookup_and_insert($signed(search_key)));
    end
    fail_count      <= mismatches;
    results_pending <= pending_outcomes.size();
  end

endmodule

[dv/testbench.sv]
module testbench;
  import sts_pkg::*;

  localparam int               CLOCK_LIMIT = 400000;
  localparam int               TOTAL_ITEMS = 900;
  // the tail of the run goes with no idling on either side
  localparam int               CALM_ITEMS  = 150;
  localparam logic [KEY_W-1:0] KEY_MIN     = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX     = 32'h7FFF_FFFF;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             out_stall  = 1'b0;
  logic [KEY_W-1:0] search_key = '0;
  logic             in_stall;
  logic             out_valid;
  logic             found;
  logic [POS_W-1:0] position;
  logic             inserted;
  logic             table_full;

  int fail_count;
  int results_pending;
  bit idle_on    = 1'b1;
  int cycles     = 0;
  int items_sent = 0;
  int stall_left = 0;

  // Keys believed to sit in the table: every new distinct key goes in until
  // the table is full. Used only to steer stimulus towards hits and near misses.
  logic signed [KEY_W-1:0] stored_keys [$];
  logic signed [KEY_W-1:0] sorted_keys [$];

  sorted_table_search_insert dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .search_key (search_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position),
    .inserted   (inserted),
    .table_full (table_full)
  );

  table_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .search_key      (search_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .found           (found),
    .position        (position),
    .inserted        (inserted),
    .table_full      (table_full),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abandon a hung run once the cycle count passes a generous ceiling.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CLOCK_LIMIT) begin
        $display("FAIL sorted_table_search_insert");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts, one assignment per edge.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
      out_stall <= (stall_left > 0);
    end
  end

  // Draw a random key, but never either extreme: those stay out of the table
  // so that a full table can still refuse keys at both of its ends.
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = $urandom; while (k == KEY_MIN || k == KEY_MAX);
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] neighbour_key();
    logic [KEY_W-1:0] k;
    k = stored_key();
    return $urandom_range(0, 1) ? k + 1 : k - 1;
  endfunction

  // Filling mix: mostly new keys, with repeats and near misses between them.
  function automatic logic [KEY_W-1:0] fill_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      6, 7:    k = stored_key();
      8, 9:    k = neighbour_key();
      default: k = fresh_key();
    endcase
    if (k == KEY_MIN || k == KEY_MAX) k = stored_key();
    return k;
  endfunction

  // Full-table mix: hits, near misses, raw noise, extremes and the two ends.
  function automatic logic [KEY_W-1:0] mixed_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 19))
      9, 10, 11, 12:      k = neighbour_key();
      13, 14, 15, 16, 17: k = $urandom;
      18:                 k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
      19:                 k = $urandom_range(0, 1) ? sorted_keys[0] - 1
                                                   : sorted_keys[TABLE_DEPTH-1] + 1;
      default:            k = stored_key();
    endcase
    return k;
  endfunction

  // Offer one item and hold it until accepted. A gap, when drawn, drops
  // valid first; otherwise valid stays high straight into the next item.
  task automatic send_key(input logic [KEY_W-1:0] key);
    bit known;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    known = 1'b0;
    foreach (stored_keys[i]) if (stored_keys[i] == $signed(key)) known = 1'b1;
    if (!known && stored_keys.size() < TABLE_DEPTH) stored_keys.push_back(key);
    in_valid   <= 1'b1;
    search_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    // Empty-table sequence: first insert, repeat hit, insert at the end, at
    // the front and in the middle, sign boundaries, keys next to entries.
    logic [KEY_W-1:0] opening_keys [14] = '{
      32'd100, 32'd100, 32'd200, 32'd50, 32'd150, 32'd150, 32'hFFFF_FFFF,
      32'd0, 32'd1, 32'h4000_0000, 32'hC000_0000, 32'd199, 32'd201, 32'd50
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_keys[i]) send_key(opening_keys[i]);
    hold_until_drained();

    // Fill the table to its last entry.
    while (stored_keys.size() < TABLE_DEPTH) send_key(fill_key());
    hold_until_drained();

    // Full table: refuse both extremes, hit the first, last and middle
    // entries, and refuse keys just outside either end; also try a key next to the middle one.
    sorted_keys = stored_keys;
    sorted_keys.sort();
    send_key(KEY_MAX);
    send_key(KEY_MIN);
    send_key(sorted_keys[0]);
    send_key(sorted_keys[TABLE_DEPTH-1]);
    send_key(sorted_keys[0] - 1);
    send_key(sorted_keys[TABLE_DEPTH-1] + 1);
    send_key(sorted_keys[TABLE_DEPTH/2]);
    send_key(sorted_keys[TABLE_DEPTH/2] + 1);

    // Random part, idling switched on and off in stretches of 50 items.
    while (items_sent < TOTAL_ITEMS - CALM_ITEMS) begin
      if (items_sent % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_key(mixed_key());
    end
    idle_on = 1'b0;
    while (items_sent < TOTAL_ITEMS) send_key(mixed_key());

    hold_until_drained();
    // Allow for a stray late result before the verdict.
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("PASS sorted_table_search_insert");
    else $display("FAIL sorted_table_search_insert");
    $finish;
  end

endmodule
